// ===== design/qrt_pkg.sv =====
// Shared widths and types for the quaternion rigid transform pipeline.
package qrt_pkg;

   localparam int unsigned CoordWidth = 32;
   localparam int unsigned ProdWidth  = 64;   // one 32x32 signed product
   localparam int unsigned NormWidth  = 65;   // a^2+b^2+c^2+d^2
   localparam int unsigned MatWidth   = 66;   // signed matrix entry (times N)
   localparam int unsigned MatLoWidth = 33;   // low chunk of a matrix entry
   localparam int unsigned MatHiWidth = MatWidth - MatLoWidth;
   localparam int unsigned PpLoWidth  = MatLoWidth + 1 + CoordWidth;
   localparam int unsigned PpHiWidth  = MatHiWidth + CoordWidth;
   localparam int unsigned SumWidth   = 100;  // signed rotated sum, also dividend
   localparam int unsigned DenWidth   = NormWidth + 1;   // 2N
   localparam int unsigned QuoWidth   = 34;   // quotient bits, one per stage
   localparam int unsigned RemWidth   = DenWidth + 1;
   localparam int unsigned ValWidth   = QuoWidth + 2;    // signed result before clamp

   localparam int unsigned Lanes = 3;

   // data that rides along the divider stages
   typedef struct packed {
      logic                         zero_norm;
      logic                         offset_present;
      logic [Lanes-1:0]             neg;
      logic [Lanes*CoordWidth-1:0]  offset;
   } side_type;

endpackage

// ===== design/qrt_div.sv =====
// Three-lane pipelined restoring divider, one quotient bit per stage, shared divisor.
module qrt_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  enable,
   input  logic                                  in_valid,
   input  logic [qrt_pkg::SumWidth-1:0]          numer [qrt_pkg::Lanes],
   input  logic [qrt_pkg::DenWidth-1:0]          denom,
   input  qrt_pkg::side_type                     in_side,
   output logic                                  out_valid,
   output logic [qrt_pkg::QuoWidth-1:0]          quot [qrt_pkg::Lanes],
   output qrt_pkg::side_type                     out_side
);

   localparam int unsigned QW = qrt_pkg::QuoWidth;
   localparam int unsigned RW = qrt_pkg::RemWidth;
   localparam int unsigned NL = qrt_pkg::Lanes;

   logic [RW-1:0]                 rem_ff [QW][NL];
   logic [RW-1:0]                 rem_in [QW][NL];
   logic [QW-1:0]                 low_ff [QW][NL];
   logic [QW-1:0]                 low_in [QW][NL];
   logic [QW-1:0]                 quo_ff [QW][NL];
   logic [QW-1:0]                 quo_in [QW][NL];
   logic [qrt_pkg::DenWidth-1:0]  den_ff [QW];
   logic [qrt_pkg::DenWidth-1:0]  den_in [QW];
   qrt_pkg::side_type             side_ff [QW];
   qrt_pkg::side_type             side_in [QW];
   logic [QW-1:0]                 vld_ff;
   logic [QW-1:0]                 vld_in;

   always_comb begin
      logic [RW-1:0] rprev;
      logic [QW-1:0] lprev;
      logic [QW-1:0] qprev;
      logic [RW-1:0] shifted;
      logic          ge;
      for (int k = 0; k < QW; k++) begin
         if (k == 0) begin
            den_in[k]  = denom;
            side_in[k] = in_side;
            vld_in[k]  = in_valid;
         end else begin
            den_in[k]  = den_ff[k-1];
            side_in[k] = side_ff[k-1];
            vld_in[k]  = vld_ff[k-1];
         end
         for (int l = 0; l < NL; l++) begin
            if (k == 0) begin
               // top bits of the dividend are already below the divisor
               rprev = {1'b0, numer[l][qrt_pkg::SumWidth-1:QW]};
               lprev = numer[l][QW-1:0];
               qprev = '0;
            end else begin
               rprev = rem_ff[k-1][l];
               lprev = low_ff[k-1][l];
               qprev = quo_ff[k-1][l];
            end
            shifted      = {rprev[RW-2:0], lprev[QW-1]};
            ge           = (shifted >= {1'b0, den_in[k]});
            rem_in[k][l] = ge ? (shifted - {1'b0, den_in[k]}) : shifted;
            low_in[k][l] = {lprev[QW-2:0], 1'b0};
            quo_in[k][l] = {qprev[QW-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         low_ff  <= low_in;
         quo_ff  <= quo_in;
         den_ff  <= den_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign quot      = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

// ===== design/quaternion_rigid_transform.sv =====
// Quaternion rotation of a Q16.16 point with optional displacement and saturation.
//
// Input beat (req_): quaternion (a, b, c vector, d scalar), point and displacement in
// req_tdata, the displacement-present flag in req_tuser. Output beat (rsp_): the moved
// point in rsp_tdata, zero_norm and clipped in rsp_tuser. One result per input beat.
// The quaternion need not be normalized: each coordinate is the exact rational
// (M*p)/N with N = a^2+b^2+c^2+d^2, rounded to nearest, ties away from zero.
// The pipeline has 7 stages of products and sums, 34 stages of the restoring
// divider (one quotient bit per stage), then the offset/clamp output register.
// Throughput is one beat per cycle while the receiver does not stall. The whole
// pipeline advances when the output register is empty or rsp_tready is high; when the
// receiver stalls, every stage holds and req_tready falls, so no beat is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
module quaternion_rigid_transform (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // quat_vec_x, quat_vec_y, quat_vec_z, quat_scalar, point_x, point_y, point_z,
   // offset_x, offset_y, offset_z (32 bits each, lowest first)
   input  logic [319:0] req_tdata,
   // offset_present
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // moved_x, moved_y, moved_z (32 bits each, lowest first)
   output logic [95:0]  rsp_tdata,
   // zero_norm, clipped
   output logic [1:0]   rsp_tuser
);

   localparam int unsigned CW = qrt_pkg::CoordWidth;
   localparam int unsigned NL = qrt_pkg::Lanes;
   localparam int unsigned MW = qrt_pkg::MatWidth;
   localparam int unsigned LW = qrt_pkg::MatLoWidth;
   localparam int unsigned SW = qrt_pkg::SumWidth;
   localparam int unsigned NW = qrt_pkg::NormWidth;
   localparam int unsigned VW = qrt_pkg::ValWidth;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic [6:0] vld_ff;
   logic [6:0] vld_in;

   // stage 1: input capture
   logic signed [CW-1:0] qa_ff, qb_ff, qc_ff, qd_ff;
   logic signed [CW-1:0] pt1_ff [NL];
   logic [NL*CW-1:0]     off1_ff;
   logic                 pres1_ff;

   // stage 2: quaternion products
   logic signed [qrt_pkg::ProdWidth-1:0] aa_ff, bb_ff, cc_ff, dd_ff;
   logic signed [qrt_pkg::ProdWidth-1:0] ab_ff, dc_ff, ac_ff, db_ff, bc_ff, da_ff;
   logic signed [CW-1:0] pt2_ff [NL];
   logic [NL*CW-1:0]     off2_ff;
   logic                 pres2_ff, zero2_ff;

   // stage 3: norm and matrix
   logic [NW-1:0]        nrm3_ff;
   logic signed [MW-1:0] mat_ff [NL][NL];
   logic signed [MW-1:0] mat_in [NL][NL];
   logic signed [CW-1:0] pt3_ff [NL];
   logic [NL*CW-1:0]     off3_ff;
   logic                 pres3_ff, zero3_ff;

   // stage 4: partial products
   logic signed [qrt_pkg::PpLoWidth-1:0] pplo_ff [NL][NL];
   logic signed [qrt_pkg::PpHiWidth-1:0] pphi_ff [NL][NL];
   logic [NW-1:0]        nrm4_ff;
   logic [NL*CW-1:0]     off4_ff;
   logic                 pres4_ff, zero4_ff;

   // stage 5: full terms
   logic signed [SW-1:0] term_ff [NL][NL];
   logic [NW-1:0]        nrm5_ff;
   logic [NL*CW-1:0]     off5_ff;
   logic                 pres5_ff, zero5_ff;

   // stage 6: row sums
   logic signed [SW-1:0] sum_ff [NL];
   logic [NW-1:0]        nrm6_ff;
   logic [NL*CW-1:0]     off6_ff;
   logic                 pres6_ff, zero6_ff;
   logic [SW-1:0]        mag6 [NL];

   // stage 7: rounding-biased dividend
   logic [SW-1:0]                 num_ff [NL];
   logic [qrt_pkg::DenWidth-1:0]  den_ff;
   qrt_pkg::side_type             side7_ff;

   logic signed [qrt_pkg::ProdWidth:0] aa_e, bb_e, cc_e, dd_e;
   // the differences need a carry bit, so widen before doubling
   logic signed [qrt_pkg::ProdWidth:0] ab_dc_m, ab_dc_p, ac_db_p, ac_db_m, bc_da_m, bc_da_p;

   always_comb begin
      aa_e = {aa_ff[qrt_pkg::ProdWidth-1], aa_ff};
      bb_e = {bb_ff[qrt_pkg::ProdWidth-1], bb_ff};
      cc_e = {cc_ff[qrt_pkg::ProdWidth-1], cc_ff};
      dd_e = {dd_ff[qrt_pkg::ProdWidth-1], dd_ff};
      ab_dc_m = {ab_ff[63], ab_ff} - {dc_ff[63], dc_ff};
      ab_dc_p = {ab_ff[63], ab_ff} + {dc_ff[63], dc_ff};
      ac_db_p = {ac_ff[63], ac_ff} + {db_ff[63], db_ff};
      ac_db_m = {ac_ff[63], ac_ff} - {db_ff[63], db_ff};
      bc_da_m = {bc_ff[63], bc_ff} - {da_ff[63], da_ff};
      bc_da_p = {bc_ff[63], bc_ff} + {da_ff[63], da_ff};
      mat_in[0][0] = MW'(aa_e + dd_e - bb_e - cc_e);
      mat_in[1][1] = MW'(bb_e + dd_e - aa_e - cc_e);
      mat_in[2][2] = MW'(cc_e + dd_e - aa_e - bb_e);
      mat_in[0][1] = {ab_dc_m, 1'b0};
      mat_in[1][0] = {ab_dc_p, 1'b0};
      mat_in[0][2] = {ac_db_p, 1'b0};
      mat_in[2][0] = {ac_db_m, 1'b0};
      mat_in[1][2] = {bc_da_m, 1'b0};
      mat_in[2][1] = {bc_da_p, 1'b0};
   end

   always_comb begin
      for (int i = 0; i < NL; i++) begin
         mag6[i] = sum_ff[i][SW-1] ? -sum_ff[i] : sum_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign vld_in = {vld_ff[5:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (adv) begin
         // stage 1
         qa_ff     <= req_tdata[31:0];
         qb_ff     <= req_tdata[63:32];
         qc_ff     <= req_tdata[95:64];
         qd_ff     <= req_tdata[127:96];
         pt1_ff[0] <= req_tdata[159:128];
         pt1_ff[1] <= req_tdata[191:160];
         pt1_ff[2] <= req_tdata[223:192];
         off1_ff   <= req_tdata[319:224];
         pres1_ff  <= req_tuser[0];
         // stage 2
         aa_ff    <= qa_ff * qa_ff;
         bb_ff    <= qb_ff * qb_ff;
         cc_ff    <= qc_ff * qc_ff;
         dd_ff    <= qd_ff * qd_ff;
         ab_ff    <= qa_ff * qb_ff;
         dc_ff    <= qd_ff * qc_ff;
         ac_ff    <= qa_ff * qc_ff;
         db_ff    <= qd_ff * qb_ff;
         bc_ff    <= qb_ff * qc_ff;
         da_ff    <= qd_ff * qa_ff;
         pt2_ff   <= pt1_ff;
         off2_ff  <= off1_ff;
         pres2_ff <= pres1_ff;
         zero2_ff <= (qa_ff == '0) && (qb_ff == '0) && (qc_ff == '0) && (qd_ff == '0);
         // stage 3
         nrm3_ff  <= {1'b0, aa_ff} + {1'b0, bb_ff} + {1'b0, cc_ff} + {1'b0, dd_ff};
         mat_ff   <= mat_in;
         pt3_ff   <= pt2_ff;
         off3_ff  <= off2_ff;
         pres3_ff <= pres2_ff;
         zero3_ff <= zero2_ff;
         // stage 4: entry split into unsigned low chunk and signed high chunk
         for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
               pplo_ff[i][j] <= $signed({1'b0, mat_ff[i][j][LW-1:0]}) * pt3_ff[j];
               pphi_ff[i][j] <= $signed(mat_ff[i][j][MW-1:LW]) * pt3_ff[j];
            end
         end
         nrm4_ff  <= nrm3_ff;
         off4_ff  <= off3_ff;
         pres4_ff <= pres3_ff;
         zero4_ff <= zero3_ff;
         // stage 5
         for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
               term_ff[i][j] <= {{2{pphi_ff[i][j][qrt_pkg::PpHiWidth-1]}}, pphi_ff[i][j],
                                 {LW{1'b0}}}
                              + {{(SW - qrt_pkg::PpLoWidth){pplo_ff[i][j][qrt_pkg::PpLoWidth-1]}},
                                 pplo_ff[i][j]};
            end
         end
         nrm5_ff  <= nrm4_ff;
         off5_ff  <= off4_ff;
         pres5_ff <= pres4_ff;
         zero5_ff <= zero4_ff;
         // stage 6
         for (int i = 0; i < NL; i++) begin
            sum_ff[i] <= term_ff[i][0] + term_ff[i][1] + term_ff[i][2];
         end
         nrm6_ff  <= nrm5_ff;
         off6_ff  <= off5_ff;
         pres6_ff <= pres5_ff;
         zero6_ff <= zero5_ff;
         // stage 7: round(|s|/N) = floor((2|s|+N)/(2N))
         for (int i = 0; i < NL; i++) begin
            num_ff[i] <= {mag6[i][SW-2:0], 1'b0} + {{(SW - NW){1'b0}}, nrm6_ff};
            side7_ff.neg[i] <= sum_ff[i][SW-1];
         end
         den_ff                  <= {nrm6_ff, 1'b0};
         side7_ff.zero_norm      <= zero6_ff;
         side7_ff.offset_present <= pres6_ff;
         side7_ff.offset         <= off6_ff;
      end
   end

   logic                          div_vld;
   logic [qrt_pkg::QuoWidth-1:0]  div_quo [NL];
   qrt_pkg::side_type             div_side;

   qrt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (vld_ff[6]),
      .numer     (num_ff),
      .denom     (den_ff),
      .in_side   (side7_ff),
      .out_valid (div_vld),
      .quot      (div_quo),
      .out_side  (div_side)
   );

   // output stage: sign, displacement, clamp
   logic                 out_vld_ff;
   logic [NL*CW-1:0]     moved_ff;
   logic [NL*CW-1:0]     moved_in;
   logic                 zero_ff, clip_ff, clip_in;

   always_comb begin
      logic signed [VW-1:0] v;
      logic signed [VW-1:0] ofs;
      clip_in  = 1'b0;
      moved_in = '0;
      for (int i = 0; i < NL; i++) begin
         v   = {2'b00, div_quo[i]};
         v   = div_side.neg[i] ? -v : v;
         ofs = {{(VW - CW){div_side.offset[i*CW + CW-1]}}, div_side.offset[i*CW +: CW]};
         if (div_side.offset_present) begin
            v = v + ofs;
         end
         if (!v[VW-1] && (|v[VW-2:CW-1])) begin
            moved_in[i*CW +: CW] = {1'b0, {(CW-1){1'b1}}};
            clip_in = 1'b1;
         end else if (v[VW-1] && !(&v[VW-2:CW-1])) begin
            moved_in[i*CW +: CW] = {1'b1, {(CW-1){1'b0}}};
            clip_in = 1'b1;
         end else begin
            moved_in[i*CW +: CW] = v[CW-1:0];
         end
      end
      if (div_side.zero_norm) begin
         moved_in = '0;
         clip_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= div_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         moved_ff <= moved_in;
         zero_ff  <= div_side.zero_norm;
         clip_ff  <= clip_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = moved_ff;
   assign rsp_tuser  = {clip_ff, zero_ff};

endmodule
